>>> src/i2c_master_register_access_macros.svh
// ---------------------------------------------------------------------------
// i2c_master_register_access_macros.svh
// assertion shorthands for the register access i2c master checker
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define MRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/i2c_mra_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_mra_pkg
// types and constants shared by the register access i2c master
// ---------------------------------------------------------------------------
package i2c_mra_pkg;

  localparam int unsigned MaxBurstDefault = 16;
  localparam logic [7:0]  DelayReset      = 8'd32;
  localparam logic [2:0]  AckTries        = 3'd5;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_A   = 4'd1,
    PH_ST_B   = 4'd2,
    PH_TX_LO  = 4'd3,
    PH_TX_HI  = 4'd4,
    PH_TX_END = 4'd5,
    PH_ACK_HI = 4'd6,
    PH_ACK_LO = 4'd7,
    PH_RX_LO  = 4'd8,
    PH_RX_HI  = 4'd9,
    PH_RX_END = 4'd10,
    PH_MA_A   = 4'd11,
    PH_MA_B   = 4'd12,
    PH_MA_C   = 4'd13,
    PH_SP_A   = 4'd14,
    PH_SP_B   = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    K_ADDR_W = 2'd0,
    K_REG    = 2'd1,
    K_DATA   = 2'd2,
    K_ADDR_R = 2'd3
  } tx_kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ADDR_NACK  = 3'd1,
    ST_REG_NACK   = 3'd2,
    ST_DATA_NACK  = 3'd3,
    ST_RADDR_NACK = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0] status;
    logic       done_res;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       sda_drive;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

>>> src/i2c_master_register_access.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_register_access
// i2c master for register writes and reads, stepped by tick requests
// ---------------------------------------------------------------------------
// Each accepted request produces exactly one result in the following cycle, and a new
// request can be taken every clock: the state update is a single combinational
// pass from the state registers into the result register, and s_axis_tready
// stays high as long as the result register is empty or being drained. A tick
// request advances bus time by one unit; delay_units ticks make one bus phase
// (0 means 256). Start and load requests are ignored while a
// transaction runs. The write data buffer is not cleared at reset; load every
// slot a burst will send before starting it.
module i2c_master_register_access #(
  parameter int unsigned MaxBurst = i2c_mra_pkg::MaxBurstDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [7:0]                        cfg_wdata_i,    // delay_units
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sda_in, slave_addr, reg_addr, byte_count, data_byte, buf_index, zero pad
  input  logic [i2c_mra_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [i2c_mra_pkg::InUserW-1:0]   s_axis_tuser,   // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // scl_out, sda_out, sda_drive, rx_byte, rx_valid, busy_res, done_res, status, pad
  output logic [i2c_mra_pkg::OutDataW-1:0]  m_axis_tdata
);
  import i2c_mra_pkg::*;

  localparam int unsigned IdxW = (MaxBurst > 1) ? $clog2(MaxBurst) : 1;
  localparam int unsigned CntW = 9;
  localparam logic [CntW-1:0] MaxBurstC = CntW'(MaxBurst);

  // unpacked request
  logic       sda_in;
  logic [6:0] slave_addr;
  logic [7:0] reg_addr;
  logic [4:0] byte_count;
  logic [7:0] data_byte;
  logic [3:0] buf_index;
  req_type_e  req_type;

  assign sda_in     = s_axis_tdata[0];
  assign slave_addr = s_axis_tdata[7:1];
  assign reg_addr   = s_axis_tdata[15:8];
  assign byte_count = s_axis_tdata[20:16];
  assign data_byte  = s_axis_tdata[28:21];
  assign buf_index  = s_axis_tdata[32:29];
  assign req_type   = req_type_e'(s_axis_tuser);

  logic [7:0] delay_units_q;
  phase_e     phase_q, phase_d;
  tx_kind_e   tx_kind_q, tx_kind_d;
  logic [7:0] period_q, period_d;
  logic [3:0] bit_q, bit_d;
  logic [4:0] byte_q, byte_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] ack_to_q, ack_to_d;
  logic       is_read_q, is_read_d;
  logic [6:0] taddr_q, taddr_d;
  logic [7:0] treg_q, treg_d;
  logic [4:0] total_q, total_d;
  logic [2:0] fail_q, fail_d;

  logic [7:0] wbuf_q [MaxBurst];
  logic            buf_we;
  logic [IdxW-1:0] buf_widx;
  logic [IdxW-1:0] buf_ridx;
  logic [CntW-1:0] ridx_ext;
  logic [CntW-1:0] widx_ext;

  logic            accept;
  logic            m_valid_q;
  result_t         res_q, res_d;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  // buffer slot for the next data byte: slot 0 after the register byte
  logic [4:0] byte_inc;
  assign byte_inc = byte_q + 5'd1;
  assign ridx_ext = (tx_kind_q == K_REG) ? '0 : {4'b0, byte_inc};
  assign buf_ridx = ridx_ext[IdxW-1:0];
  assign widx_ext = {5'b0, buf_index};
  assign buf_widx = widx_ext[IdxW-1:0];

  always_comb begin
    logic       busy;
    logic [3:0] bit_inc;
    logic [2:0] to_inc;
    logic [4:0] cnt;
    logic       obit;
    logic       ackbit;
    logic       rxv;
    logic       done;
    logic [7:0] rx;

    busy     = (phase_q != PH_IDLE);
    bit_inc  = bit_q + 4'd1;
    to_inc   = ack_to_q + 3'd1;
    cnt      = 5'd0;
    rxv      = 1'b0;
    done     = 1'b0;
    rx       = 8'd0;
    buf_we   = 1'b0;

    phase_d   = phase_q;
    tx_kind_d = tx_kind_q;
    period_d  = period_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    ack_to_d  = ack_to_q;
    is_read_d = is_read_q;
    taddr_d   = taddr_q;
    treg_d    = treg_q;
    total_d   = total_q;
    fail_d    = fail_q;

    case (req_type)
      REQ_TICK: begin
        if (busy) begin
          period_d = period_q + 8'd1;
          if (period_d == delay_units_q) begin
            period_d = 8'd0;
            case (phase_q)
              PH_ST_A: phase_d = PH_ST_B;
              PH_ST_B: begin
                shift_d = {taddr_q, (tx_kind_q == K_ADDR_R)};
                bit_d   = 4'd0;
                phase_d = PH_TX_LO;
              end
              PH_TX_LO: phase_d = PH_TX_HI;
              PH_TX_HI: phase_d = PH_TX_END;
              PH_TX_END: begin
                shift_d = {shift_q[6:0], 1'b0};
                bit_d   = bit_inc;
                if (bit_inc >= 4'd8) begin
                  ack_to_d = 3'd0;
                  phase_d  = PH_ACK_HI;
                end else begin
                  phase_d = PH_TX_LO;
                end
              end
              PH_ACK_HI: begin
                if (!sda_in) begin
                  phase_d = PH_ACK_LO;
                end else begin
                  ack_to_d = to_inc;
                  if (to_inc >= AckTries) begin
                    fail_d  = {1'b0, tx_kind_q} + 3'd1;
                    phase_d = PH_SP_A;
                  end
                end
              end
              PH_ACK_LO: begin
                case (tx_kind_q)
                  K_ADDR_W: begin
                    tx_kind_d = K_REG;
                    shift_d   = treg_q;
                    bit_d     = 4'd0;
                    phase_d   = PH_TX_LO;
                  end
                  K_REG: begin
                    byte_d = 5'd0;
                    if (is_read_q) begin
                      tx_kind_d = K_ADDR_R;
                      phase_d   = PH_ST_A;
                    end else begin
                      tx_kind_d = K_DATA;
                      shift_d   = wbuf_q[buf_ridx];
                      bit_d     = 4'd0;
                      phase_d   = PH_TX_LO;
                    end
                  end
                  K_DATA: begin
                    byte_d = byte_inc;
                    if (byte_inc >= total_q || {4'b0, byte_inc} >= MaxBurstC) begin
                      phase_d = PH_SP_A;
                    end else begin
                      shift_d = wbuf_q[buf_ridx];
                      bit_d   = 4'd0;
                      phase_d = PH_TX_LO;
                    end
                  end
                  default: begin
                    byte_d  = 5'd0;
                    bit_d   = 4'd0;
                    shift_d = 8'd0;
                    phase_d = PH_RX_LO;
                  end
                endcase
              end
              PH_RX_LO: phase_d = PH_RX_HI;
              PH_RX_HI: begin
                shift_d = {shift_q[6:0], sda_in};
                bit_d   = bit_inc;
                if (bit_inc >= 4'd8) begin
                  rx      = shift_d;
                  rxv     = 1'b1;
                  phase_d = PH_RX_END;
                end else begin
                  phase_d = PH_RX_LO;
                end
              end
              PH_RX_END: phase_d = PH_MA_A;
              PH_MA_A:   phase_d = PH_MA_B;
              PH_MA_B:   phase_d = PH_MA_C;
              PH_MA_C: begin
                byte_d = byte_inc;
                if (byte_inc >= total_q) begin
                  phase_d = PH_SP_A;
                end else begin
                  bit_d   = 4'd0;
                  shift_d = 8'd0;
                  phase_d = PH_RX_LO;
                end
              end
              PH_SP_A: phase_d = PH_SP_B;
              PH_SP_B: begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end
      REQ_LOAD: begin
        if (!busy && widx_ext < MaxBurstC) begin
          buf_we = 1'b1;
        end
      end
      default: begin
        if (!busy) begin
          cnt = (byte_count == 5'd0) ? 5'd1 : byte_count;
          if ({4'b0, cnt} > MaxBurstC) begin
            cnt = MaxBurstC[4:0];
          end
          total_d   = cnt;
          taddr_d   = slave_addr;
          treg_d    = reg_addr;
          is_read_d = (req_type == REQ_READ);
          tx_kind_d = K_ADDR_W;
          fail_d    = ST_OK;
          byte_d    = 5'd0;
          bit_d     = 4'd0;
          ack_to_d  = 3'd0;
          period_d  = 8'd0;
          phase_d   = PH_ST_A;
        end
      end
    endcase

    // pin levels follow the phase after the update
    obit   = shift_d[7];
    ackbit = ({1'b0, byte_d} + 6'd1 >= {1'b0, total_d});

    res_d           = '0;
    res_d.rx_byte   = rx;
    res_d.rx_valid  = rxv;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.status    = done ? fail_d : ST_OK;
    case (phase_d)
      PH_ST_A:                       {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b111;
      PH_ST_B:                       {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b101;
      PH_TX_LO, PH_TX_END:           {res_d.scl_out, res_d.sda_out, res_d.sda_drive} =
                                       {1'b0, obit, 1'b1};
      PH_TX_HI:                      {res_d.scl_out, res_d.sda_out, res_d.sda_drive} =
                                       {1'b1, obit, 1'b1};
      PH_ACK_HI, PH_RX_HI:           {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b100;
      PH_ACK_LO, PH_RX_LO, PH_RX_END: {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b000;
      PH_MA_A, PH_MA_C:              {res_d.scl_out, res_d.sda_out, res_d.sda_drive} =
                                       {1'b0, ackbit, 1'b1};
      PH_MA_B:                       {res_d.scl_out, res_d.sda_out, res_d.sda_drive} =
                                       {1'b1, ackbit, 1'b1};
      PH_SP_A:                       {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b001;
      PH_SP_B:                       {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b101;
      default:                       {res_d.scl_out, res_d.sda_out, res_d.sda_drive} = 3'b111;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_units_q <= DelayReset;
    end else if (cfg_we_i) begin
      delay_units_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tx_kind_q <= K_ADDR_W;
      period_q  <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      shift_q   <= '0;
      ack_to_q  <= '0;
      is_read_q <= 1'b0;
      taddr_q   <= '0;
      treg_q    <= '0;
      total_q   <= '0;
      fail_q    <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      tx_kind_q <= tx_kind_d;
      period_q  <= period_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      shift_q   <= shift_d;
      ack_to_q  <= ack_to_d;
      is_read_q <= is_read_d;
      taddr_q   <= taddr_d;
      treg_q    <= treg_d;
      total_q   <= total_d;
      fail_q    <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && buf_we) begin
      wbuf_q[buf_widx] <= data_byte;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

>>> src/i2c_mra_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_mra_props
// port-level checks for the register access i2c master
// ---------------------------------------------------------------------------
`include "i2c_master_register_access_macros.svh"

module i2c_mra_props (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [i2c_mra_pkg::OutDataW-1:0] m_axis_tdata
);
  import i2c_mra_pkg::*;

  logic s_acc;
  logic out_v;
  logic stall;
  logic scl, sdo, drv, rxv, busy, done;
  logic [2:0] st;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign out_v = m_axis_tvalid;
  assign stall = m_axis_tvalid && !m_axis_tready;
  assign scl   = m_axis_tdata[0];
  assign sdo   = m_axis_tdata[1];
  assign drv   = m_axis_tdata[2];
  assign rxv   = m_axis_tdata[11];
  assign busy  = m_axis_tdata[12];
  assign done  = m_axis_tdata[13];
  assign st    = m_axis_tdata[16:14];

  `MRA_ASSERT_NEXT(a_result_held, stall, out_v && $stable(m_axis_tdata), "result moved in stall")
  `MRA_ASSERT_NEXT(a_request_gives_result, s_acc, out_v, "accepted request left no result")
  `MRA_ASSERT_NOW(a_done_idle, out_v && done, !busy && scl && sdo && drv, "bus busy after done")
  `MRA_ASSERT_NOW(a_rx_inside_transfer, out_v && rxv, busy && !done, "rx byte outside transfer")
  `MRA_ASSERT_NOW(a_status_only_on_done, out_v && !done, st == ST_OK, "status without done")

endmodule

bind i2c_master_register_access i2c_mra_props u_checker (.*);

>>> sim/i2c_mra_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_mra_checker
// watches both stream channels of the i2c register access master, predicts
// the pin levels, received bytes and status that each request yields, and
// compares every result with the oldest pending prediction
// ---------------------------------------------------------------------------
module i2c_mra_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [7:0]                       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [i2c_mra_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [i2c_mra_pkg::InUserW-1:0]  s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [i2c_mra_pkg::OutDataW-1:0] m_axis_tdata,
  output int unsigned                      fail_count,
  output int unsigned                      results_owed
);
  import i2c_mra_pkg::*;

  localparam int unsigned BurstLen = MaxBurstDefault;
  localparam int unsigned PadW     = OutDataW - $bits(result_t);

  // shadow copy of the bus engine
  phase_e     bus_phase;
  tx_kind_e   sending;
  status_e    fail_status;
  logic [7:0] delay_q;
  logic [7:0] tick_count;
  logic [7:0] shifter;
  logic [3:0] bit_idx;
  logic [4:0] byte_idx;
  logic [4:0] byte_total;
  logic [2:0] nack_tries;
  logic       read_op;
  logic [6:0] dev_addr;
  logic [7:0] reg_byte;
  logic [7:0] wbuf [BurstLen];

  result_t    pin_results_q [$];
  result_t    want;
  result_t    got;

  task automatic begin_byte(input logic [7:0] value);
    shifter   = value;
    bit_idx   = '0;
    bus_phase = PH_TX_LO;
  endtask

  // one bus phase has elapsed, sda sampled at its close
  task automatic end_of_period(input logic sda, inout result_t res);
    case (bus_phase)
      PH_ST_A: bus_phase = PH_ST_B;
      PH_ST_B: begin_byte({dev_addr, sending == K_ADDR_R});
      PH_TX_LO: bus_phase = PH_TX_HI;
      PH_TX_HI: bus_phase = PH_TX_END;
      PH_TX_END: begin
        shifter = shifter << 1;
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) begin
          nack_tries = '0;
          bus_phase  = PH_ACK_HI;
        end else begin
          bus_phase = PH_TX_LO;
        end
      end
      PH_ACK_HI: begin
        if (!sda) begin
          bus_phase = PH_ACK_LO;
        end else begin
          nack_tries = nack_tries + 3'd1;
          if (nack_tries >= AckTries) begin
            fail_status = status_e'({1'b0, sending} + 3'd1);
            bus_phase   = PH_SP_A;
          end
        end
      end
      PH_ACK_LO: begin
        case (sending)
          K_ADDR_W: begin
            sending = K_REG;
            begin_byte(reg_byte);
          end
          K_REG: begin
            byte_idx = '0;
            if (read_op) begin
              sending   = K_ADDR_R;
              bus_phase = PH_ST_A;
            end else begin
              sending = K_DATA;
              begin_byte(wbuf[0]);
            end
          end
          K_DATA: begin
            byte_idx = byte_idx + 5'd1;
            if (byte_idx >= byte_total || byte_idx >= BurstLen) begin
              bus_phase = PH_SP_A;
            end else begin
              begin_byte(wbuf[byte_idx[3:0]]);
            end
          end
          default: begin
            byte_idx  = '0;
            bit_idx   = '0;
            shifter   = '0;
            bus_phase = PH_RX_LO;
          end
        endcase
      end
      PH_RX_LO: bus_phase = PH_RX_HI;
      PH_RX_HI: begin
        shifter = {shifter[6:0], sda};
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) begin
          res.rx_byte  = shifter;
          res.rx_valid = 1'b1;
          bus_phase    = PH_RX_END;
        end else begin
          bus_phase = PH_RX_LO;
        end
      end
      PH_RX_END: bus_phase = PH_MA_A;
      PH_MA_A: bus_phase = PH_MA_B;
      PH_MA_B: bus_phase = PH_MA_C;
      PH_MA_C: begin
        byte_idx = byte_idx + 5'd1;
        if (byte_idx >= byte_total) begin
          bus_phase = PH_SP_A;
        end else begin
          bit_idx   = '0;
          shifter   = '0;
          bus_phase = PH_RX_LO;
        end
      end
      PH_SP_A: bus_phase = PH_SP_B;
      PH_SP_B: begin
        bus_phase    = PH_IDLE;
        res.done_res = 1'b1;
      end
      default: bus_phase = PH_IDLE;
    endcase
  endtask

  // apply one request and work out the result it yields
  task automatic bus_step(input req_type_e kind, input logic [InDataW-1:0] word,
                          output result_t res);
    logic       busy;
    logic       tx_bit;
    logic       master_ack;
    logic [4:0] cnt;
    res    = '0;
    busy   = (bus_phase != PH_IDLE);
    cnt    = word[20:16];
    if (kind == REQ_TICK) begin
      if (busy) begin
        tick_count = tick_count + 8'd1;
        if (tick_count == delay_q) begin
          tick_count = '0;
          end_of_period(word[0], res);
        end
      end else begin
        bus_phase = PH_IDLE;
      end
    end else if (!busy) begin
      if (kind == REQ_LOAD) begin
        wbuf[word[32:29]] = word[28:21];
      end else begin
        if (cnt == 5'd0) cnt = 5'd1;
        if (cnt > BurstLen) cnt = 5'(BurstLen);
        byte_total  = cnt;
        dev_addr    = word[7:1];
        reg_byte    = word[15:8];
        read_op     = (kind == REQ_READ);
        sending     = K_ADDR_W;
        fail_status = ST_OK;
        byte_idx    = '0;
        bit_idx     = '0;
        nack_tries  = '0;
        tick_count  = '0;
        bus_phase   = PH_ST_A;
      end
    end

    res.status   = res.done_res ? fail_status : ST_OK;
    res.busy_res = (bus_phase != PH_IDLE);
    tx_bit       = shifter[7];
    // the receiver acks every byte but the last
    master_ack   = (int'(byte_idx) + 1 >= int'(byte_total));
    case (bus_phase)
      PH_ST_B: begin
        res.scl_out = 1'b1; res.sda_out = 1'b0; res.sda_drive = 1'b1;
      end
      PH_TX_LO, PH_TX_END: begin
        res.scl_out = 1'b0; res.sda_out = tx_bit; res.sda_drive = 1'b1;
      end
      PH_TX_HI: begin
        res.scl_out = 1'b1; res.sda_out = tx_bit; res.sda_drive = 1'b1;
      end
      PH_ACK_HI, PH_RX_HI: begin
        res.scl_out = 1'b1; res.sda_out = 1'b0; res.sda_drive = 1'b0;
      end
      PH_ACK_LO, PH_RX_LO, PH_RX_END: begin
        res.scl_out = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b0;
      end
      PH_MA_A, PH_MA_C: begin
        res.scl_out = 1'b0; res.sda_out = master_ack; res.sda_drive = 1'b1;
      end
      PH_MA_B: begin
        res.scl_out = 1'b1; res.sda_out = master_ack; res.sda_drive = 1'b1;
      end
      PH_SP_A: begin
        res.scl_out = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b1;
      end
      PH_SP_B: begin
        res.scl_out = 1'b1; res.sda_out = 1'b0; res.sda_drive = 1'b1;
      end
      default: begin
        res.scl_out = 1'b1; res.sda_out = 1'b1; res.sda_drive = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_phase    = PH_IDLE;
      sending      = K_ADDR_W;
      fail_status  = ST_OK;
      delay_q      = DelayReset;
      tick_count   = '0;
      shifter      = '0;
      bit_idx      = '0;
      byte_idx     = '0;
      byte_total   = '0;
      nack_tries   = '0;
      read_op      = 1'b0;
      dev_addr     = '0;
      reg_byte     = '0;
      pin_results_q.delete();
      results_owed = 0;
      fail_count   = 0;
    end else begin
      // a result always leaves after the edge that accepts its request, so pop first
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (pin_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result %h arrived with nothing pending", $realtime, m_axis_tdata);
          end
        end else begin
          want = pin_results_q.pop_front();
          if (m_axis_tdata !== {{PadW{1'b0}}, want}) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch exp/act scl %b/%b sda %b/%b drive %b/%b rx %h/%h",
                       $realtime, want.scl_out, got.scl_out, want.sda_out, got.sda_out,
                       want.sda_drive, got.sda_drive, want.rx_byte, got.rx_byte);
              $display("  rxv %b/%b busy %b/%b done %b/%b status %0d/%0d pad 0/%h",
                       want.rx_valid, got.rx_valid, want.busy_res, got.busy_res,
                       want.done_res, got.done_res, want.status, got.status,
                       m_axis_tdata[OutDataW-1:$bits(result_t)]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bus_step(req_type_e'(s_axis_tuser), s_axis_tdata, want);
        pin_results_q.push_back(want);
      end
      if (cfg_we_i) delay_q = cfg_wdata_i;
      results_owed = pin_results_q.size();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives register write and read transactions through the i2c master
// ---------------------------------------------------------------------------
// Loads the write buffer, then starts transfers and steps bus time with tick
// requests while answering on sda with ack-all, biased, noisy, cut-off and
// dead slave behavior. Directed transfers hit the address, register, data and
// read-address nacks and zero and oversized byte counts; random transfers
// follow under three sender/receiver idling mixes. Ignored commands are mixed
// in while a transfer runs. A checker module predicts and compares every
// result.
module testbench;
  import i2c_mra_pkg::*;

  typedef enum int {
    SDA_ACK_ALL,
    SDA_BIASED,
    SDA_NOISY,
    SDA_CUT,
    SDA_DEAD
  } sda_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [7:0]          cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = REQ_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned done_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 58;
  int unsigned cur_delay     = 32;
  int unsigned tick_no       = 0;
  int unsigned cut_at        = 0;
  sda_mode_e   sda_mode      = SDA_BIASED;
  result_t     out_view;

  always #1 clk_i = ~clk_i;

  i2c_master_register_access u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  i2c_mra_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  assign out_view = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // end of transfer as seen on the result channel
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready && out_view.done_res) begin
      done_count <= done_count + 1;
    end
  end

  function automatic logic [InDataW-1:0] request_word(
    input logic sda, input logic [6:0] addr, input logic [7:0] rg,
    input logic [4:0] cnt, input logic [7:0] data, input logic [3:0] slot);
    return {7'b0, slot, data, cnt, rg, addr, sda};
  endfunction

  function automatic logic [InDataW-1:0] random_word();
    return {7'b0, 1'($urandom), 32'($urandom)};
  endfunction

  // slave side of sda as seen on the closing tick of a bus period
  function automatic logic next_sda();
    case (sda_mode)
      SDA_ACK_ALL: return 1'b0;
      SDA_BIASED:  return ($urandom_range(0, 3) == 0);
      SDA_NOISY:   return 1'($urandom);
      SDA_CUT:     return (tick_no >= cut_at);
      default:     return 1'b1;
    endcase
  endfunction

  task automatic push_request(input req_type_e kind, input logic [InDataW-1:0] word);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic push_tick();
    logic [InDataW-1:0] word;
    word    = random_word();
    word[0] = next_sda();
    push_request(REQ_TICK, word);
    tick_no++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (results_owed == 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_delay(input logic [7:0] units);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= units;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_delay = units;
  endtask

  task automatic run_transfer(input logic is_rd, input logic [6:0] addr, input logic [7:0] rg,
                              input logic [4:0] cnt, input sda_mode_e mode, input int cut);
    int unsigned done_mark;
    repeat ($urandom_range(0, 2)) push_tick();
    repeat ($urandom_range(0, 2)) begin
      push_request(REQ_LOAD, random_word());
    end
    sda_mode  = mode;
    cut_at    = cut;
    tick_no   = 0;
    done_mark = done_count;
    push_request(is_rd ? REQ_READ : REQ_WRITE,
                 request_word(1'($urandom), addr, rg, cnt, 8'($urandom), 4'($urandom)));
    while (done_count == done_mark) begin
      // even a dead slave keeps the block busy for over 30 periods, so these get ignored
      if (tick_no < 30 * cur_delay && $urandom_range(0, 19) == 0) begin
        push_request(req_type_e'($urandom_range(1, 3)), random_word());
      end else begin
        push_tick();
      end
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    logic        is_rd;
    logic [4:0]  cnt;
    sda_mode_e   mode;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill every buffer slot so no burst ever sends an unwritten one
    for (int slot = 0; slot < 16; slot++) begin
      push_request(REQ_LOAD, request_word(1'b0, '0, '0, '0,
                   slot == 0 ? 8'h00 : slot == 15 ? 8'hff : 8'($urandom), 4'(slot)));
    end
    set_delay(8'd1);
    // oversized count is cut to a full sixteen byte burst
    run_transfer(1'b0, 7'h7f, 8'hff, 5'd31, SDA_ACK_ALL, 0);
    run_transfer(1'b1, 7'h55, 8'haa, 5'd0, SDA_ACK_ALL, 0);
    run_transfer(1'b1, 7'h33, 8'hcc, 5'd2, SDA_NOISY, 0);
    run_transfer(1'b0, 7'h11, 8'h22, 5'd3, SDA_DEAD, 0);
    // cut points after the address ack, after the register ack
    run_transfer(1'b0, 7'h12, 8'h34, 5'd2, SDA_CUT, 40);
    run_transfer(1'b0, 7'h56, 8'h78, 5'd2, SDA_CUT, 60);
    run_transfer(1'b1, 7'h1b, 8'he4, 5'd2, SDA_CUT, 60);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 17 : 0;
      set_delay(8'($urandom_range(1, 2)));
      target = items_sent + 220;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) == 0) begin
          set_delay(8'($urandom_range(1, 2)));
        end
        is_rd = 1'($urandom);
        cnt   = 5'($urandom_range(0, 2));
        pick  = $urandom_range(0, 19);
        mode = (pick < 11) ? SDA_BIASED : (pick < 14) ? SDA_NOISY :
               (pick < 19) ? SDA_CUT : SDA_DEAD;
        run_transfer(is_rd, 7'($urandom), 8'($urandom), cnt, mode,
                     $urandom_range(0, 150 * cur_delay));
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
